// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level RTL of the color correction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk_i, hold off while rst_ni is low.
`define WCC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check on every rising edge of clk_i, reset included.
`define WCC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

// ===== hdl/wcc_pkg.sv =====
// Types and constants of the weighted color correction block.
`timescale 1ns / 1ps

package wcc_pkg;

  // Channel order: blue, green, red.
  localparam int NumCh = 3;
  localparam int PixW  = 8;
  localparam logic [PixW-1:0] PixMax = 8'd255;

  // Weight is unsigned Q1.WeightFracBits.
  localparam int WeightFracBits = 16;
  localparam int QuoW           = WeightFracBits + 1;
  localparam logic [QuoW-1:0] WeightOne = QuoW'(1) << WeightFracBits;

  // Divider: quotient bits resolved per pipeline stage.
  localparam int DivBitsPerStage = 4;
  localparam int DivStages = (WeightFracBits + DivBitsPerStage - 1) / DivBitsPerStage;

  // Correction is sample minus target, signed.
  localparam int CorrW = PixW + 1;
  localparam int ProdW = CorrW + QuoW + 1;
  localparam int ValW  = ProdW + 1;

  // Pipeline: entry, divider stages, multiply, output.
  localparam int NumStg = DivStages + 3;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    RegSampleBlue  = 3'd0,
    RegSampleGreen = 3'd1,
    RegSampleRed   = 3'd2,
    RegTargetBlue  = 3'd3,
    RegTargetGreen = 3'd4,
    RegTargetRed   = 3'd5
  } cfg_reg_e;

  localparam logic [PixW-1:0] SampleRst [NumCh] = '{8'd170, 8'd160, 8'd170};
  localparam logic [PixW-1:0] TargetRst [NumCh] = '{8'd20, 8'd40, 8'd220};

endpackage

// ===== hdl/weighted_color_correction_top.sv =====
// Top level of the weighted color correction pipeline.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------------
//  pixel in | sink      | in_valid_i / in_stall_o   | blue_in_i, green_in_i, red_in_i
//  pixel out| source    | out_valid_o / out_stall_i | blue_out_o, green_out_o, red_out_o
//  config   | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel per clock while the output is not stalled, through NumStg = DivStages + 3
// register stages (7 with 16 weight fraction bits): an entry stage, four divider stages
// of four restoring steps each, a 9x17 multiply stage and a saturating output stage.
// The divider stages set the depth. Reset clears the valid bits and loads the
// sample/target registers with their defaults. A stalled output freezes the whole
// pipeline; in_stall_o follows at once, so no transaction is dropped or repeated.
// Config writes are always taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module weighted_color_correction_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // pixel in
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [wcc_pkg::PixW-1:0]     blue_in_i,
  input  logic [wcc_pkg::PixW-1:0]     green_in_i,
  input  logic [wcc_pkg::PixW-1:0]     red_in_i,
  // pixel out
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [wcc_pkg::PixW-1:0]     blue_out_o,
  output logic [wcc_pkg::PixW-1:0]     green_out_o,
  output logic [wcc_pkg::PixW-1:0]     red_out_o,
  // config
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wcc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wcc_pkg::CfgDataW-1:0] cfg_data_i
);
  import wcc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PixW-1:0] sample_q [NumCh];
  logic [PixW-1:0] target_q [NumCh];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < NumCh; ch++) begin
        sample_q[ch] <= SampleRst[ch];
        target_q[ch] <= TargetRst[ch];
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        RegSampleBlue:  sample_q[0] <= cfg_data_i;
        RegSampleGreen: sample_q[1] <= cfg_data_i;
        RegSampleRed:   sample_q[2] <= cfg_data_i;
        RegTargetBlue:  target_q[0] <= cfg_data_i;
        RegTargetGreen: target_q[1] <= cfg_data_i;
        RegTargetRed:   target_q[2] <= cfg_data_i;
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: one global advance, frozen by a stalled output
  // ---------------------------------------------------------------------------
  logic [NumStg-1:0] vld_q;
  logic              adv;

  assign adv        = !(vld_q[NumStg-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[NumStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStg-2:0], in_valid_i};
    end
  end

  logic [PixW-1:0] pix_in [NumCh];
  logic [PixW-1:0] pix_out_q [NumCh];

  assign pix_in[0] = blue_in_i;
  assign pix_in[1] = green_in_i;
  assign pix_in[2] = red_in_i;

  assign blue_out_o  = pix_out_q[0];
  assign green_out_o = pix_out_q[1];
  assign red_out_o   = pix_out_q[2];

  // ---------------------------------------------------------------------------
  // Per channel datapath
  // ---------------------------------------------------------------------------
  // Divider pipeline registers, index 0 is the entry stage.
  logic [PixW-1:0]         rem_q  [NumCh][DivStages+1];
  logic [QuoW-1:0]         quo_q  [NumCh][DivStages+1];
  logic [PixW-1:0]         den_q  [NumCh][DivStages+1];
  logic signed [CorrW-1:0] corr_q [NumCh][DivStages+1];
  logic [PixW-1:0]         pix_q  [NumCh][DivStages+1];
  logic                    wone_q [NumCh][DivStages+1];

  // Multiply stage
  logic signed [ProdW-1:0] prod_q  [NumCh];
  logic [PixW-1:0]         pixm_q  [NumCh];

  for (genvar ch = 0; ch < NumCh; ch++) begin : g_ch

    // Entry: distance from the sample, denominator, correction.
    logic [PixW-1:0]         gap;
    logic [PixW-1:0]         den_d;
    logic [PixW-1:0]         rem_d;
    logic [QuoW-1:0]         quo_d;
    logic signed [CorrW-1:0] corr_d;
    logic                    wone_d;

    always_comb begin
      if (pix_in[ch] < sample_q[ch]) begin
        gap   = sample_q[ch] - pix_in[ch];
        den_d = sample_q[ch];
      end else begin
        gap   = pix_in[ch] - sample_q[ch];
        den_d = PixMax - sample_q[ch];
      end
      // Full weight at zero distance or zero denominator.
      wone_d = (gap == '0) || (den_d == '0);
      // Leading quotient bit: set only when the distance equals the denominator.
      if (gap == den_d) begin
        quo_d = QuoW'(1);
        rem_d = '0;
      end else begin
        quo_d = '0;
        rem_d = gap;
      end
      corr_d = $signed({1'b0, sample_q[ch]}) - $signed({1'b0, target_q[ch]});
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[ch][0]  <= rem_d;
        quo_q[ch][0]  <= quo_d;
        den_q[ch][0]  <= den_d;
        corr_q[ch][0] <= corr_d;
        pix_q[ch][0]  <= pix_in[ch];
        wone_q[ch][0] <= wone_d;
      end
    end

    // Restoring divider, DivBitsPerStage quotient bits per stage.
    for (genvar s = 0; s < DivStages; s++) begin : g_div
      logic [PixW-1:0] rem_nx;
      logic [QuoW-1:0] quo_nx;

      always_comb begin
        logic [PixW:0] sh;
        sh     = '0;
        rem_nx = rem_q[ch][s];
        quo_nx = quo_q[ch][s];
        for (int k = 0; k < DivBitsPerStage; k++) begin
          if (s * DivBitsPerStage + k < WeightFracBits) begin
            sh = {rem_nx, 1'b0};
            if (sh >= {1'b0, den_q[ch][s]}) begin
              rem_nx = PixW'(sh - {1'b0, den_q[ch][s]});
              quo_nx = {quo_nx[QuoW-2:0], 1'b1};
            end else begin
              rem_nx = sh[PixW-1:0];
              quo_nx = {quo_nx[QuoW-2:0], 1'b0};
            end
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[ch][s+1]  <= rem_nx;
          quo_q[ch][s+1]  <= quo_nx;
          den_q[ch][s+1]  <= den_q[ch][s];
          corr_q[ch][s+1] <= corr_q[ch][s];
          pix_q[ch][s+1]  <= pix_q[ch][s];
          wone_q[ch][s+1] <= wone_q[ch][s];
        end
      end
    end

    // Weight and correction product.
    logic [QuoW-1:0]         weight;
    logic signed [ProdW-1:0] corr_x;
    logic signed [ProdW-1:0] weight_x;
    logic signed [ProdW-1:0] prod_d;

    always_comb begin
      weight   = wone_q[ch][DivStages] ? WeightOne : WeightOne - quo_q[ch][DivStages];
      corr_x   = ProdW'(corr_q[ch][DivStages]);
      weight_x = $signed(ProdW'(weight));
      prod_d   = corr_x * weight_x;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        prod_q[ch] <= prod_d;
        pixm_q[ch] <= pix_q[ch][DivStages];
      end
    end

    // Subtract from the scaled pixel, truncate, saturate.
    logic signed [ValW-1:0] val;
    logic [PixW-1:0]        pix_out_d;

    always_comb begin
      val = $signed(ValW'({pixm_q[ch], WeightFracBits'(0)})) - ValW'(prod_q[ch]);
      if (val <= 0) begin
        pix_out_d = '0;
      end else if (|val[ValW-1:WeightFracBits+PixW]) begin
        pix_out_d = PixMax;
      end else begin
        pix_out_d = val[WeightFracBits+PixW-1:WeightFracBits];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pix_out_q[ch] <= pix_out_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `WCC_ASSERT(a_freeze_holds_valids, !adv |=> vld_q == $past(vld_q),
              "pipeline valid bits moved during a stall")
  `WCC_ASSERT_ALWAYS(a_stall_only_when_full, in_stall_o |-> vld_q[NumStg-1],
                     "input stalled while the output stage is empty")

  for (genvar ch = 0; ch < NumCh; ch++) begin : g_chk
    `WCC_ASSERT(a_rem_below_den,
                (den_q[ch][DivStages] != '0) |-> (rem_q[ch][DivStages] < den_q[ch][DivStages]),
                "divider remainder not below denominator")
    `WCC_ASSERT(a_quo_in_range,
                (den_q[ch][DivStages] != '0) |-> (quo_q[ch][DivStages] <= WeightOne),
                "divider quotient exceeds one")
  end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the weighted color correction pipeline.
`timescale 1ns / 1ps

module tb;
  import wcc_pkg::*;

  // One BGR pixel, as seen on either side of the pipeline.
  typedef struct packed {
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
  } bgr_t;

  localparam int ChBlue  = 0;
  localparam int ChGreen = 1;
  localparam int ChRed   = 2;

  // Settling wait after the last result, sized from the pipeline depth.
  localparam int Settle = NumStg + 4;

  // Block after this many random pixels, then load a fresh white setting.
  localparam int PixelsPerSetting = 50;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [PixW-1:0]     blue_in_i   = '0;
  logic [PixW-1:0]     green_in_i  = '0;
  logic [PixW-1:0]     red_in_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PixW-1:0]     blue_out_o;
  logic [PixW-1:0]     green_out_o;
  logic [PixW-1:0]     red_out_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Shadow copy of the sample/target registers, loaded with the reset values.
  logic [PixW-1:0] white_sample [NumCh] = SampleRst;
  logic [PixW-1:0] white_target [NumCh] = TargetRst;

  // Corrected pixels that the pipeline still owes us, oldest first.
  bgr_t corrected_q [$];

  // Percent chance per cycle that the pixel source idles / the sink stalls.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int fail_count   = 0;

  weighted_color_correction_top DUT (.*);

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Pull one channel toward its target. The weight is Q1.WeightFracBits: one at
  // the sample value, falling linearly to zero at 0 (below) or 255 (above).
  function automatic logic [PixW-1:0] corrected_level(input logic [PixW-1:0] pix,
                                                      input logic [PixW-1:0] sample,
                                                      input logic [PixW-1:0] target);
    longint one;
    longint p;
    longint s;
    longint corr;
    longint gap;
    longint denom;
    longint weight;
    longint level;
    one  = longint'(1) << WeightFracBits;
    p    = longint'(pix);
    s    = longint'(sample);
    corr = s - longint'(target);
    if (p < s) begin
      gap   = s - p;
      denom = s;
    end else begin
      gap   = p - s;
      denom = longint'(PixMax) - s;
    end
    // A zero denominator only comes with zero distance: weight is exactly one.
    if (gap == 0 || denom == 0) begin
      weight = one;
    end else begin
      weight = one - (gap << WeightFracBits) / denom;
    end
    level = p * one - corr * weight;
    if (level <= 0) begin
      return '0;
    end
    level = level >>> WeightFracBits;
    if (level > longint'(PixMax)) begin
      return PixMax;
    end
    return level[PixW-1:0];
  endfunction

  function automatic bgr_t expected_pixel(input bgr_t pix);
    bgr_t res;
    res.blue  = corrected_level(pix.blue, white_sample[ChBlue], white_target[ChBlue]);
    res.green = corrected_level(pix.green, white_sample[ChGreen], white_target[ChGreen]);
    res.red   = corrected_level(pix.red, white_sample[ChRed], white_target[ChRed]);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall and result checking
  // ---------------------------------------------------------------------------

  // Drive the sink stall at the falling edge so it is stable at the rising edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  // Compare every accepted result with the oldest pending expectation.
  always @(posedge clk_i) begin : check_result
    bgr_t want;
    bgr_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{blue: blue_out_o, green: green_out_o, red: red_out_o};
      if (corrected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: unexpected result b=%0d g=%0d r=%0d", $realtime,
                   got.blue, got.green, got.red);
        end
      end else begin
        want = corrected_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: mismatch expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                     $realtime, want.blue, want.green, want.red,
                     got.blue, got.green, got.red);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered and left just after a falling edge.
  // ---------------------------------------------------------------------------

  // Write one register; cfg_valid_i stays high so back-to-back writes
  // do not lower and raise it in the same step.
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    // The write lands on this edge: mirror it in the shadow registers.
    case (idx)
      RegSampleBlue:  white_sample[ChBlue]  = value;
      RegSampleGreen: white_sample[ChGreen] = value;
      RegSampleRed:   white_sample[ChRed]   = value;
      RegTargetBlue:  white_target[ChBlue]  = value;
      RegTargetGreen: white_target[ChGreen] = value;
      RegTargetRed:   white_target[ChRed]   = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Load all six registers; call only with the pipeline drained.
  task automatic set_white(input logic [PixW-1:0] s_blue, input logic [PixW-1:0] s_green,
                           input logic [PixW-1:0] s_red, input logic [PixW-1:0] t_blue,
                           input logic [PixW-1:0] t_green, input logic [PixW-1:0] t_red);
    write_reg(RegSampleBlue, s_blue);
    write_reg(RegSampleGreen, s_green);
    write_reg(RegSampleRed, s_red);
    write_reg(RegTargetBlue, t_blue);
    write_reg(RegTargetGreen, t_green);
    write_reg(RegTargetRed, t_red);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one pixel, with random idle cycles ahead of it, and hold it until
  // the pipeline takes the transaction. in_valid_i is left high on return.
  task automatic send_pixel(input bgr_t pix);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    blue_in_i  <= pix.blue;
    green_in_i <= pix.green;
    red_in_i   <= pix.red;
    do @(posedge clk_i); while (in_stall_o);
    corrected_q = {corrected_q, expected_pixel(pix)};
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every pending result is back and the pipe is empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (corrected_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus helpers
  // ---------------------------------------------------------------------------

  // Channel level biased toward the sample value and the range ends.
  function automatic logic [PixW-1:0] pick_level(input logic [PixW-1:0] sample);
    int lvl;
    case ($urandom_range(9))
      0: lvl = int'(sample);
      1: lvl = int'(sample) + int'($urandom_range(6)) - 3;
      2: lvl = 0;
      3: lvl = int'(PixMax);
      default: lvl = int'($urandom_range(255));
    endcase
    if (lvl < 0) lvl = 0;
    if (lvl > int'(PixMax)) lvl = int'(PixMax);
    return lvl[PixW-1:0];
  endfunction

  function automatic bgr_t random_pixel();
    bgr_t pix;
    pix.blue  = pick_level(white_sample[ChBlue]);
    pix.green = pick_level(white_sample[ChGreen]);
    pix.red   = pick_level(white_sample[ChRed]);
    return pix;
  endfunction

  // Sample register: mostly in the useful range, sometimes at or past its ends.
  function automatic logic [PixW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return PixMax;
      2: return 8'd1;
      3: return PixMax - 8'd1;
      default: return PixW'($urandom_range(1, 254));
    endcase
  endfunction

  function automatic logic [PixW-1:0] pick_target();
    case ($urandom_range(7))
      0: return '0;
      1: return PixMax;
      default: return PixW'($urandom_range(255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: pixel at the sample, one step either side, and the range ends.
  task automatic test_reset_defaults();
    send_pixel('{blue: 8'd0, green: 8'd0, red: 8'd0});
    send_pixel('{blue: 8'd255, green: 8'd255, red: 8'd255});
    send_pixel('{blue: 8'd170, green: 8'd160, red: 8'd170});
    send_pixel('{blue: 8'd169, green: 8'd159, red: 8'd169});
    send_pixel('{blue: 8'd171, green: 8'd161, red: 8'd171});
    send_pixel('{blue: 8'd128, green: 8'd1, red: 8'd254});
    send_pixel('{blue: 8'd85, green: 8'd170, red: 8'd200});
    drain();
  endtask

  // Sample registers at and past their meant ends, targets at 0 and 255.
  task automatic test_white_extremes();
    // Sample 255 with pixel 255 has a zero denominator; target 0 with a
    // rounded weight drives the value below zero, which must clamp to 0.
    set_white(8'd255, 8'd0, 8'd200, 8'd0, 8'd255, 8'd0);
    send_pixel('{blue: 8'd255, green: 8'd0, red: 8'd133});
    send_pixel('{blue: 8'd0, green: 8'd255, red: 8'd255});
    send_pixel('{blue: 8'd254, green: 8'd1, red: 8'd199});
    send_pixel('{blue: 8'd128, green: 8'd128, red: 8'd0});
    send_pixel('{blue: 8'd255, green: 8'd255, red: 8'd201});
    drain();
    // Blue and green samples one step inside the meant range, red sample 128, targets all at full scale.
    set_white(8'd1, 8'd254, 8'd128, 8'd255, 8'd255, 8'd255);
    send_pixel('{blue: 8'd0, green: 8'd0, red: 8'd0});
    send_pixel('{blue: 8'd1, green: 8'd254, red: 8'd128});
    send_pixel('{blue: 8'd255, green: 8'd255, red: 8'd255});
    send_pixel('{blue: 8'd2, green: 8'd253, red: 8'd127});
    drain();
  endtask

  // Random pixels under random white settings at one idle/stall mix.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int num_pixels);
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    for (int i = 0; i < num_pixels; i++) begin
      if (i % PixelsPerSetting == 0) begin
        drain();
        set_white(pick_sample(), pick_sample(), pick_sample(),
                  pick_target(), pick_target(), pick_target());
      end
      send_pixel(random_pixel());
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_white_extremes();
    test_random_traffic(0, 0, 214);
    test_random_traffic(85, 0, 214);
    test_random_traffic(0, 85, 214);
    test_random_traffic(16, 16, 214);

    // Give any stray result time to show up before the verdict.
    rx_stall_pct = 0;
    repeat (Settle) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
